// ----- rtl/http_request_line_checker_assert.svh -----
// Assertion macros for the checker file of this block.
`ifndef HTTP_REQUEST_LINE_CHECKER_ASSERT_SVH
`define HTTP_REQUEST_LINE_CHECKER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define HRLC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property on every rising clock edge, reset included.
`define HRLC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

// ----- rtl/hrlc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hrlc_pkg;

  localparam int unsigned LineMaxDefault = 256;
  localparam int unsigned NumMethods     = 9;

  localparam logic [3:0] VersionLen = 4'd8;
  localparam logic [3:0] CitMax     = 4'd15;
  localparam logic [1:0] TokMax     = 2'd3;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Method names, right-aligned: the last character sits in the low byte
  localparam logic [63:0] MethodName [NumMethods] = '{
    64'("GET"), 64'("HEAD"), 64'("POST"), 64'("PUT"), 64'("DELETE"),
    64'("CONNECT"), 64'("OPTIONS"), 64'("TRACE"), 64'("PATCH")
  };
  localparam logic [3:0] MethodLen [NumMethods] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
  };
  localparam logic [39:0] VersionPrefix = "HTTP/";

  typedef enum logic [2:0] {
    CauseOk,
    CauseNoLineEnd,
    CauseEmpty,
    CauseTooLong,
    CauseBadMethod,
    CauseBadVersion,
    CauseExtraToken
  } fail_cause_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       request_ok;
    logic [2:0] fail_cause;
  } result_t;

  typedef struct packed {
    logic [1:0]            token_number;
    logic [3:0]            char_in_token;
    logic [NumMethods-1:0] method_candidates;
    logic                  version_good;
    logic                  inside_token;
    fail_cause_e           first_failure;
  } tok_state_t;

  function automatic tok_state_t tok_reset();
    tok_state_t s;
    s.token_number      = '0;
    s.char_in_token     = '0;
    s.method_candidates = '1;
    s.version_good      = 1'b1;
    s.inside_token      = 1'b0;
    s.first_failure     = CauseOk;
    return s;
  endfunction

  // Keep only the first failure of the line
  function automatic tok_state_t note_failure(tok_state_t s, fail_cause_e c);
    if (s.first_failure == CauseOk) begin
      s.first_failure = c;
    end
    return s;
  endfunction

  // Character k of method i; meaningful only while k is below the length
  function automatic logic [7:0] method_char(int unsigned i, logic [3:0] k);
    logic [2:0] pos;
    pos = 3'(MethodLen[i] - 4'd1 - k);
    return MethodName[i][8*pos +: 8];
  endfunction

  // Close the current token and judge it
  function automatic tok_state_t finish_token(tok_state_t s);
    logic ok;
    ok = 1'b0;
    if (s.token_number == 2'd0) begin
      for (int unsigned i = 0; i < NumMethods; i++) begin
        if (s.method_candidates[i] && (MethodLen[i] == s.char_in_token)) begin
          ok = 1'b1;
        end
      end
      if (!ok) begin
        s = note_failure(s, CauseBadMethod);
      end
    end else if (s.token_number == 2'd2) begin
      if (!(s.version_good && (s.char_in_token == VersionLen))) begin
        s = note_failure(s, CauseBadVersion);
      end
    end
    s.inside_token = 1'b0;
    if (s.token_number < TokMax) begin
      s.token_number = s.token_number + 2'd1;
    end
    return s;
  endfunction

  // Advance the token state by one character of the line
  function automatic tok_state_t ordinary_char(tok_state_t s, logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (c == ChSpace) begin
      if (s.inside_token) begin
        s = finish_token(s);
      end
    end else begin
      if (!s.inside_token) begin
        s.inside_token      = 1'b1;
        s.char_in_token     = '0;
        s.method_candidates = '1;
        s.version_good      = 1'b1;
        if (s.token_number == TokMax) begin
          s = note_failure(s, CauseExtraToken);
        end
      end
      if (s.token_number == 2'd0) begin
        for (int unsigned i = 0; i < NumMethods; i++) begin
          if ((s.char_in_token >= MethodLen[i]) ||
              (method_char(i, s.char_in_token) != c)) begin
            s.method_candidates[i] = 1'b0;
          end
        end
      end else if (s.token_number == 2'd2) begin
        if (s.char_in_token < 4'd5) begin
          ok = (VersionPrefix[8*(3'(4'd4 - s.char_in_token)) +: 8] == c);
        end else if (s.char_in_token == 4'd6) begin
          ok = (c == ChDot);
        end else if (s.char_in_token < VersionLen) begin
          ok = (c >= ChZero) && (c <= ChNine);
        end else begin
          ok = 1'b0;
        end
        if (!ok) begin
          s.version_good = 1'b0;
        end
      end
      if (s.char_in_token < CitMax) begin
        s.char_in_token = s.char_in_token + 4'd1;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hrlc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hrlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/hrlc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hrlc_out_if;
  logic       valid;
  logic       ready;
  logic       request_ok;
  logic [2:0] fail_cause;

  modport source (output valid, output request_ok, output fail_cause, input ready);
  modport sink (input valid, input request_ok, input fail_cause, output ready);
endinterface

`default_nettype wire

// ----- rtl/hrlc_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrlc_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  hrlc_in_if.sink             in_i,
  input  wire logic           take_i,
  output hrlc_pkg::item_t     item_o,
  output logic                valid_o
);

  logic            valid_q;
  logic            valid_d;
  hrlc_pkg::item_t item_q;

  // Accept a byte when empty or the held one leaves in the same cycle
  assign in_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until the parser takes it
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.last      <= in_i.last;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- rtl/hrlc_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrlc_parser #(
  parameter int unsigned LINE_MAX = hrlc_pkg::LineMaxDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire hrlc_pkg::item_t  item_i,
  input  wire logic             free_i,
  output logic                  take_o,
  output logic                  res_valid_o,
  output hrlc_pkg::result_t     res_o
);

  localparam int unsigned    LenW   = $clog2(LINE_MAX + 1);
  localparam logic [LenW:0]  LenSat = (LenW + 1)'(LINE_MAX);

  hrlc_pkg::tok_state_t  tok_q, tok_d, tok_s;
  logic [LenW-1:0]       len_q, len_d;
  logic                  pend_q, pend_d;
  logic                  given_q, given_d;
  logic                  emit;
  hrlc_pkg::fail_cause_e cause;
  logic [1:0]            nchar;
  logic [LenW:0]         len_sum;

  assign take_o = valid_i && free_i;

  // Work out the effect of one byte on the line state
  always_comb begin
    tok_s   = tok_q;
    pend_d  = pend_q;
    given_d = given_q;
    emit    = 1'b0;
    cause   = hrlc_pkg::CauseOk;
    nchar   = 2'd0;
    if (!given_q) begin
      if (item_i.data_byte == hrlc_pkg::ChNul) begin
        emit  = 1'b1;
        cause = hrlc_pkg::CauseNoLineEnd;
      end else if (pend_q && (item_i.data_byte == hrlc_pkg::ChLf)) begin
        pend_d = 1'b0;
        emit   = 1'b1;
        if (tok_s.inside_token) begin
          tok_s = hrlc_pkg::finish_token(tok_s);
        end
        if (len_q == '0) begin
          cause = hrlc_pkg::CauseEmpty;
        end else if ({1'b0, len_q} >= LenSat) begin
          cause = hrlc_pkg::CauseTooLong;
        end else begin
          cause = tok_s.first_failure;
        end
      end else begin
        // A CR not followed by LF is an ordinary character
        if (pend_q) begin
          tok_s = hrlc_pkg::ordinary_char(tok_s, hrlc_pkg::ChCr);
          nchar = nchar + 2'd1;
        end
        pend_d = (item_i.data_byte == hrlc_pkg::ChCr);
        if (item_i.data_byte != hrlc_pkg::ChCr) begin
          tok_s = hrlc_pkg::ordinary_char(tok_s, item_i.data_byte);
          nchar = nchar + 2'd1;
        end
        if (item_i.last) begin
          emit  = 1'b1;
          cause = hrlc_pkg::CauseNoLineEnd;
        end
      end
      given_d = emit;
    end
  end

  // Saturate the line length at the limit
  always_comb begin
    len_sum = {1'b0, len_q} + (LenW + 1)'(nchar);
    len_d   = (len_sum >= LenSat) ? LenSat[LenW-1:0] : len_sum[LenW-1:0];
    tok_d   = tok_s;
  end

  // Update state per byte; the last byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= hrlc_pkg::tok_reset();
      len_q   <= '0;
      pend_q  <= 1'b0;
      given_q <= 1'b0;
    end else if (take_o) begin
      if (item_i.last) begin
        tok_q   <= hrlc_pkg::tok_reset();
        len_q   <= '0;
        pend_q  <= 1'b0;
        given_q <= 1'b0;
      end else begin
        tok_q   <= tok_d;
        len_q   <= len_d;
        pend_q  <= pend_d;
        given_q <= given_d;
      end
    end
  end

  assign res_valid_o      = take_o && emit;
  assign res_o.request_ok = (cause == hrlc_pkg::CauseOk);
  assign res_o.fail_cause = cause;

endmodule

`default_nettype wire

// ----- rtl/hrlc_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrlc_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire hrlc_pkg::result_t res_i,
  output logic                   free_o,
  hrlc_out_if.source             out_o
);

  logic              valid_q;
  logic              valid_d;
  hrlc_pkg::result_t res_q;

  // Room when empty or when the held verdict leaves this cycle
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the verdict while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.request_ok = res_q.request_ok;
  assign out_o.fail_cause = res_q.fail_cause;

endmodule

`default_nettype wire

// ----- rtl/http_request_line_checker.sv -----
// Request line checker for a byte stream carrying HTTP requests.
// Input channel in_i: one byte per transfer with a last flag that closes the
// request buffer. A zero byte also ends the data.
// Output channel out_o: at most one verdict per request, request_ok and
// fail_cause (0 ok, 1 no line end, 2 empty line, 3 too long, 4 bad method,
// 5 bad version, 6 extra token). The verdict comes with the LF of the first
// CR LF pair, or with the end of data when no line end was seen.
// A byte transferred on in_i is held in the input register; its verdict is
// registered in the output stage when the parser takes the byte, and is
// presented on out_o from then on until it transfers.
// Throughput: one byte per cycle while no verdict stalls on out_o; the parse
// state update is a single registered step of at most two characters per
// byte. Reset clears the valid flags of both stage registers and the parse
// state. After the byte flagged last the parse state returns to its reset
// values. A stall on out_o while a verdict is held freezes the parse state:
// the input register takes one more byte if it is empty, then in_i.ready
// drops until the verdict transfers.
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_checker #(
  parameter int unsigned LINE_MAX = hrlc_pkg::LineMaxDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hrlc_in_if.sink     in_i,
  hrlc_out_if.source  out_o
);

  hrlc_pkg::item_t   item;
  hrlc_pkg::result_t res;
  logic              item_valid;
  logic              take;
  logic              free;
  logic              res_valid;

  hrlc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .item_o  (item),
    .valid_o (item_valid)
  );

  hrlc_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .item_i      (item),
    .free_i      (free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hrlc_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ----- rtl/hrlc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_line_checker_assert.svh"

module hrlc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_ok_i,
  input wire logic [2:0] out_cause_i
);

  // Verdict flag agrees with the cause code
  `HRLC_ASSERT(ok_matches_cause,
    out_valid_i |-> (out_ok_i == (out_cause_i == hrlc_pkg::CauseOk)),
    "request_ok disagrees with fail_cause")

  // Cause code stays within the defined codes
  `HRLC_ASSERT(cause_in_range,
    out_valid_i |-> (out_cause_i <= hrlc_pkg::CauseExtraToken),
    "fail_cause out of range")

  // A stalled verdict holds
  `HRLC_ASSERT(stall_holds,
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_ok_i) && $stable(out_cause_i)),
    "verdict changed while stalled")

  // Input is never blocked while the output side has room
  `HRLC_ASSERT_ALWAYS(ready_when_room,
    (!out_valid_i || out_ready_i) |-> in_ready_i,
    "input stalled with free output")

  // Input ready only ever drops behind a held verdict
  `HRLC_ASSERT(ready_drop_cause,
    (in_valid_i && !in_ready_i) |-> (out_valid_i && !out_ready_i),
    "input stalled without output stall")

endmodule

bind http_request_line_checker hrlc_checker u_hrlc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ok_i    (out_o.request_ok),
  .out_cause_i (out_o.fail_cause)
);

`default_nettype wire
